### design/slwm_pkg.sv
// ----------------------------------------------------------------------------
// slwm_pkg: shared types and constants for the sliding window statistics block
// Holds the sample widths, the default window depth and the control structs
// that pass between the sequencer and the sorted store engine.
// ----------------------------------------------------------------------------
package slwm_pkg;

  localparam int WINDOW_DEFAULT = 64;
  localparam int SAMPLE_W       = 32;
  localparam int VAL_W          = 31;
  localparam int CNT_W          = 32;

  // Operations the sorted store engine carries out.
  typedef enum logic [1:0] {
    OP_REMOVE = 2'd0,
    OP_INSERT = 2'd1,
    OP_PEEK   = 2'd2
  } sort_op_t;

  typedef struct packed {
    logic             start;
    sort_op_t         op;
    logic [VAL_W-1:0] value;
  } sort_cmd_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] minimum;
    logic [VAL_W-1:0] mid_lo;
    logic [VAL_W-1:0] mid_hi;
    logic [VAL_W-1:0] maximum;
  } sort_stat_t;

endpackage

### design/slwm_divider.sv
// ----------------------------------------------------------------------------
// slwm_divider: serial restoring divider
// Produces one quotient bit per cycle; the quotient is held until the next start.
// ----------------------------------------------------------------------------
module slwm_divider import slwm_pkg::*; #(
  parameter int NUM_W = 37,
  parameter int DEN_W = 7,
  parameter int QUO_W = VAL_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  acc;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem, acc[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(NUM_W);
      acc   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      // Shift the next numerator bit into the remainder and try to subtract.
      if (fits) begin
        rem <= diff[DEN_W-1:0];
        acc <= {acc[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        acc <= {acc[NUM_W-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = acc[QUO_W-1:0];

endmodule

### design/slwm_sort_engine.sv
// ----------------------------------------------------------------------------
// slwm_sort_engine: sorted sample store with a single compare-and-shift unit
// Removes one copy of a value, inserts a value in order, or reads out the
// minimum, the two middle entries and the maximum, one entry per cycle.
// ----------------------------------------------------------------------------
module slwm_sort_engine import slwm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int OCC_W = $clog2(WINDOW + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  sort_cmd_t        cmd,
  input  logic [OCC_W-1:0] count,
  output sort_stat_t       stat
);

  typedef enum logic [4:0] {
    E_IDLE     = 5'b00001,
    E_REMOVE   = 5'b00010,
    E_INSERT   = 5'b00100,
    E_INS_LAST = 5'b01000,
    E_PEEK     = 5'b10000
  } eng_state_t;

  eng_state_t       state;
  logic [VAL_W-1:0] mem [WINDOW];
  logic [VAL_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             we;

  logic [VAL_W-1:0] value_r;
  logic [OCC_W-1:0] n_r;
  logic [OCC_W-1:0] ptr;
  logic [OCC_W-1:0] ptr_m1;
  logic [OCC_W-1:0] pend_idx;
  logic [OCC_W-1:0] pend_m1;
  logic [OCC_W-1:0] pend_p1;
  logic [OCC_W-1:0] n_m1;
  logic [OCC_W-1:0] half;
  logic [OCC_W-1:0] lo_idx;
  logic             pend;
  logic             found;
  logic [2:0]       step;
  logic             done;
  logic [VAL_W-1:0] min_r;
  logic [VAL_W-1:0] lo_r;
  logic [VAL_W-1:0] hi_r;
  logic [VAL_W-1:0] max_r;

  assign ptr_m1  = ptr - 1'b1;
  assign pend_m1 = pend_idx - 1'b1;
  assign pend_p1 = pend_idx + 1'b1;
  assign n_m1    = n_r - 1'b1;
  assign half    = n_r >> 1;
  assign lo_idx  = (half == '0) ? '0 : half - 1'b1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    unique case (state)
      E_IDLE: begin
      end
      E_REMOVE: begin
        if (ptr != n_r) begin
          rd_addr = ptr[IDX_W-1:0];
        end
        // Once the match is passed, every later entry moves down one place.
        if (pend && found) begin
          we      = 1'b1;
          wr_addr = pend_m1[IDX_W-1:0];
        end
      end
      E_INSERT: begin
        if (ptr != '0) begin
          rd_addr = ptr_m1[IDX_W-1:0];
        end
        if (pend) begin
          we      = 1'b1;
          wr_addr = pend_p1[IDX_W-1:0];
          wr_data = (rd_data > value_r) ? rd_data : value_r;
        end
      end
      E_INS_LAST: begin
        we      = 1'b1;
        wr_addr = '0;
        wr_data = value_r;
      end
      E_PEEK: begin
        case (step)
          3'd0:    rd_addr = '0;
          3'd1:    rd_addr = lo_idx[IDX_W-1:0];
          3'd2:    rd_addr = half[IDX_W-1:0];
          default: rd_addr = n_m1[IDX_W-1:0];
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (cmd.start) begin
            value_r <= cmd.value;
            n_r     <= count;
            found   <= 1'b0;
            pend    <= 1'b0;
            step    <= '0;
            case (cmd.op)
              OP_REMOVE: begin
                ptr   <= '0;
                state <= E_REMOVE;
              end
              OP_INSERT: begin
                ptr   <= count;
                state <= (count == '0) ? E_INS_LAST : E_INSERT;
              end
              default: begin
                state <= E_PEEK;
              end
            endcase
          end
        end
        E_REMOVE: begin
          if (ptr != n_r) begin
            ptr      <= ptr + 1'b1;
            pend     <= 1'b1;
            pend_idx <= ptr;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (!found && rd_data == value_r) begin
              found <= 1'b1;
            end
            if (pend_idx == n_m1) begin
              pend  <= 1'b0;
              done  <= 1'b1;
              state <= E_IDLE;
            end
          end
        end
        E_INSERT: begin
          if (ptr != '0) begin
            ptr      <= ptr_m1;
            pend     <= 1'b1;
            pend_idx <= ptr_m1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (rd_data > value_r) begin
              // Every entry was larger, so the new value goes to the bottom.
              if (pend_idx == '0) begin
                pend  <= 1'b0;
                state <= E_INS_LAST;
              end
            end else begin
              pend  <= 1'b0;
              done  <= 1'b1;
              state <= E_IDLE;
            end
          end
        end
        E_INS_LAST: begin
          done  <= 1'b1;
          state <= E_IDLE;
        end
        E_PEEK: begin
          step <= step + 1'b1;
          case (step)
            3'd1: min_r <= rd_data;
            3'd2: lo_r  <= rd_data;
            3'd3: hi_r  <= rd_data;
            3'd4: begin
              max_r <= rd_data;
              done  <= 1'b1;
              state <= E_IDLE;
            end
            default: begin
            end
          endcase
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  assign stat.done    = done;
  assign stat.minimum = min_r;
  assign stat.mid_lo  = lo_r;
  assign stat.mid_hi  = hi_r;
  assign stat.maximum = max_r;

endmodule

### design/sliding_window_median_stats.sv
// Flow: a clear, or a dropped sample on an empty window, goes from acceptance through
// the stats and done states to the result register. A dropped sample on a filled window
// waits for the serial divider for the mean, which works through the 37-bit window total
// bit by bit. A taken sample also waits for the sorted insert, and an eviction before it
// for the sorted remove. A new transaction is taken only once the previous result is
// loaded, which waits while the output is stalled. Reset clears the counters and handshake.
// ----------------------------------------------------------------------------
// sliding_window_median_stats: windowed median, mean, minimum and maximum
// Keeps the last WINDOW positive Q16.16 samples in arrival order and in sorted
// order, and reports the window statistics after every input transaction.
// ----------------------------------------------------------------------------
module sliding_window_median_stats import slwm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int OCC_W = $clog2(WINDOW + 1),
  localparam int TOT_W = VAL_W + $clog2(WINDOW)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       command,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VAL_W-1:0]           median,
  output logic [VAL_W-1:0]           mean,
  output logic [VAL_W-1:0]           minimum,
  output logic [VAL_W-1:0]           maximum,
  output logic [OCC_W-1:0]           occupancy,
  output logic [CNT_W-1:0]           accepted_count,
  output logic                       taken
);

  // The sequencer walks one transaction through eviction, sorted remove, sorted insert
  // and the statistics read-out, skipping the steps it does not need. Remove and insert
  // wait for the sorted store engine, a non-empty read-out for it and the divider.
  typedef enum logic [7:0] {
    S_IDLE      = 8'b00000001,
    S_EVICT     = 8'b00000010,
    S_REMOVE    = 8'b00000100,
    S_INSERT_GO = 8'b00001000,
    S_INSERT    = 8'b00010000,
    S_STATS_GO  = 8'b00100000,
    S_STATS     = 8'b01000000,
    S_DONE      = 8'b10000000
  } seq_state_t;

  seq_state_t       state;

  // Arrival ring: written once per taken sample, read continuously at the
  // oldest slot so the evicted value is ready the cycle after acceptance.
  logic [VAL_W-1:0] ring [WINDOW];
  logic [VAL_W-1:0] ring_q;
  logic             ring_we;
  logic [IDX_W-1:0] ring_waddr;
  logic [VAL_W-1:0] ring_wdata;
  logic [IDX_W:0]   tail_sum;
  logic [IDX_W:0]   tail_wrap;

  logic [TOT_W-1:0] total;
  logic [OCC_W-1:0] fill;
  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] tally;
  logic [VAL_W-1:0] value_r;
  logic             taken_r;
  logic             peek_seen;

  logic             accept;
  logic             positive;
  logic             full;
  logic [OCC_W-1:0] fill_m1;

  sort_cmd_t        sort_cmd;
  logic [OCC_W-1:0] sort_count;
  sort_stat_t       sort_stat;

  logic             div_start;
  logic             div_busy;
  logic [VAL_W-1:0] div_quot;

  logic [VAL_W:0]   mid_sum;
  logic [VAL_W-1:0] median_calc;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign positive = !sample[SAMPLE_W-1] && (sample != '0);
  assign full     = (fill == OCC_W'(WINDOW));
  assign fill_m1  = fill - 1'b1;

  // Slot after the newest sample; the sum stays below twice the depth, so a
  // single compare and subtract wraps it.
  assign tail_sum  = {1'b0, oldest} + (IDX_W + 1)'(fill);
  assign tail_wrap = (tail_sum >= (IDX_W + 1)'(WINDOW)) ?
                     tail_sum - (IDX_W + 1)'(WINDOW) : tail_sum;

  // The value written to the ring is the incoming sample at acceptance, or
  // the held sample when it replaces the oldest one.
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = tail_wrap[IDX_W-1:0];
    ring_wdata = sample[VAL_W-1:0];
    if (accept && !command && positive && !full) begin
      ring_we = 1'b1;
    end else if (state == S_EVICT) begin
      ring_we    = 1'b1;
      ring_waddr = oldest;
      ring_wdata = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
    ring_q <= ring[oldest];
  end

  // Commands to the sorted store engine. A full window first removes the
  // evicted value, then every taken sample is inserted, then the four order
  // statistics are read out from a non-empty window.
  always_comb begin
    sort_cmd.start = 1'b0;
    sort_cmd.op    = OP_PEEK;
    sort_cmd.value = value_r;
    sort_count     = fill;
    unique case (state)
      S_EVICT: begin
        sort_cmd.start = 1'b1;
        sort_cmd.op    = OP_REMOVE;
        sort_cmd.value = ring_q;
        sort_count     = OCC_W'(WINDOW);
      end
      S_INSERT_GO: begin
        sort_cmd.start = 1'b1;
        sort_cmd.op    = OP_INSERT;
        sort_count     = fill_m1;
      end
      S_STATS_GO: begin
        sort_cmd.start = (fill != '0);
      end
      default: begin
      end
    endcase
  end

  assign div_start = (state == S_STATS_GO) && (fill != '0);

  slwm_sort_engine #(
    .WINDOW (WINDOW)
  ) u_sort (
    .clk   (clk),
    .rst   (rst),
    .cmd   (sort_cmd),
    .count (sort_count),
    .stat  (sort_stat)
  );

  slwm_divider #(
    .NUM_W (TOT_W),
    .DEN_W (OCC_W),
    .QUO_W (VAL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (total),
    .den      (fill),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // For an even count the median is the truncated mean of the two middle
  // entries; for an odd count it is the single middle entry.
  assign mid_sum     = {1'b0, sort_stat.mid_lo} + {1'b0, sort_stat.mid_hi};
  assign median_calc = fill[0] ? sort_stat.mid_hi : mid_sum[VAL_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      fill      <= '0;
      oldest    <= '0;
      tally     <= '0;
      taken_r   <= 1'b0;
      peek_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value_r <= sample[VAL_W-1:0];
            if (command) begin
              // Clear: the window empties and the count restarts.
              total   <= '0;
              fill    <= '0;
              oldest  <= '0;
              tally   <= '0;
              taken_r <= 1'b0;
              state   <= S_STATS_GO;
            end else if (positive) begin
              taken_r <= 1'b1;
              if (tally != '1) begin
                tally <= tally + 1'b1;
              end
              if (full) begin
                state <= S_EVICT;
              end else begin
                total <= total + TOT_W'(sample[VAL_W-1:0]);
                fill  <= fill + 1'b1;
                state <= S_INSERT_GO;
              end
            end else begin
              // A zero or negative sample is dropped and the window stands.
              taken_r <= 1'b0;
              state   <= S_STATS_GO;
            end
          end
        end
        S_EVICT: begin
          total  <= total - TOT_W'(ring_q) + TOT_W'(value_r);
          oldest <= (oldest == IDX_W'(WINDOW - 1)) ? '0 : oldest + 1'b1;
          state  <= S_REMOVE;
        end
        S_REMOVE: begin
          if (sort_stat.done) begin
            state <= S_INSERT_GO;
          end
        end
        S_INSERT_GO: begin
          state <= S_INSERT;
        end
        S_INSERT: begin
          if (sort_stat.done) begin
            state <= S_STATS_GO;
          end
        end
        S_STATS_GO: begin
          peek_seen <= 1'b0;
          state     <= (fill == '0) ? S_DONE : S_STATS;
        end
        S_STATS: begin
          if (sort_stat.done) begin
            peek_seen <= 1'b1;
          end
          if ((peek_seen || sort_stat.done) && !div_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // The result register frees up when the previous result is taken.
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            median         <= (fill == '0) ? '0 : median_calc;
            mean           <= (fill == '0) ? '0 : div_quot;
            minimum        <= (fill == '0) ? '0 : sort_stat.minimum;
            maximum        <= (fill == '0) ? '0 : sort_stat.maximum;
            occupancy      <= fill;
            accepted_count <= tally;
            taken          <= taken_r;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_median_stats
// Sends directed and random sample and clear transactions with random gaps
// and stalls on both sides, predicts every result with a software copy of
// the window, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import slwm_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int DEPTH        = WINDOW_DEFAULT;
  localparam int OCC_W        = $clog2(DEPTH + 1);
  localparam int TOT_W        = VAL_W + $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 1050;
  // The limit allows several times the slowest item plus the longest sender gap
  // and receiver stall, per item.
  localparam int LIMIT_CYCLES = 1500000;
  // Enough cycles after the last result for a slow item to show up uninvited.
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_PRINTED  = 40;

  // Command codes carried on the command port.
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // One result of the block, as the bench expects or observes it.
  typedef struct {
    logic [VAL_W-1:0] median;
    logic [VAL_W-1:0] mean;
    logic [VAL_W-1:0] minimum;
    logic [VAL_W-1:0] maximum;
    logic [OCC_W-1:0] occupancy;
    logic [CNT_W-1:0] accepted_count;
    logic             taken;
  } window_stats_t;

  // The scoreboard keeps its own copy of the window, in arrival order and in
  // sorted order, and queues the statistics each accepted transaction should
  // produce. Results are matched against the oldest queued entry.
  class window_scoreboard;
    logic [VAL_W-1:0] arrivals [DEPTH];
    logic [VAL_W-1:0] ranked   [DEPTH];
    logic [TOT_W-1:0] window_sum;
    int unsigned      fill;
    int unsigned      head;
    logic [CNT_W-1:0] tally;
    window_stats_t    awaited [$];
    int unsigned      errors;
    int unsigned      items_seen;
    int unsigned      clears_seen;
    int unsigned      drops_seen;
    int unsigned      evictions_seen;
    int unsigned      results_checked;

    function new();
      window_sum = '0;
      fill = 0;
      head = 0;
      tally = '0;
      errors = 0;
      items_seen = 0;
      clears_seen = 0;
      drops_seen = 0;
      evictions_seen = 0;
      results_checked = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("MISMATCH: %s", what);
    endtask

    // Drops the first copy of v from the sorted view; duplicates stay.
    function void unrank(logic [VAL_W-1:0] v);
      int unsigned i;
      i = 0;
      while (i < fill && ranked[i] != v) i++;
      if (i >= fill) return;
      while (i + 1 < fill) begin
        ranked[i] = ranked[i + 1];
        i++;
      end
    endfunction

    // Inserts v into a sorted view of n entries; equal values keep order.
    function void rank(logic [VAL_W-1:0] v, int unsigned n);
      int unsigned i;
      i = n;
      while (i > 0 && ranked[i - 1] > v) begin
        ranked[i] = ranked[i - 1];
        i--;
      end
      ranked[i] = v;
    endfunction

    function void admit(logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] oldest;
      if (fill >= DEPTH) begin
        oldest = arrivals[head];
        unrank(oldest);
        window_sum -= TOT_W'(oldest);
        fill = DEPTH - 1;
        arrivals[head] = v;
        head = (head + 1) % DEPTH;
        rank(v, fill);
        fill = DEPTH;
        evictions_seen++;
      end else begin
        arrivals[(head + fill) % DEPTH] = v;
        rank(v, fill);
        fill++;
      end
      window_sum += TOT_W'(v);
      if (tally != '1) tally++;
    endfunction

    // Called for every accepted input transaction.
    function void note_input(logic cmd, logic [SAMPLE_W-1:0] smp);
      window_stats_t    exp;
      logic [VAL_W:0]   pair_sum;
      int unsigned      half;
      exp.taken = 1'b0;
      items_seen++;
      if (cmd == CMD_CLEAR) begin
        window_sum = '0;
        fill = 0;
        head = 0;
        tally = '0;
        clears_seen++;
      end else if (smp != '0 && !smp[SAMPLE_W-1]) begin
        admit(smp[VAL_W-1:0]);
        exp.taken = 1'b1;
      end else begin
        drops_seen++;
      end
      exp.median  = '0;
      exp.mean    = '0;
      exp.minimum = '0;
      exp.maximum = '0;
      if (fill > 0) begin
        half = fill / 2;
        if (fill % 2 == 0) begin
          // The pair is summed one bit wider so the middle value is exact.
          pair_sum = {1'b0, ranked[half - 1]} + {1'b0, ranked[half]};
          exp.median = pair_sum[VAL_W:1];
        end else begin
          exp.median = ranked[half];
        end
        exp.mean    = VAL_W'(window_sum / TOT_W'(fill));
        exp.minimum = ranked[0];
        exp.maximum = ranked[fill - 1];
      end
      exp.occupancy      = OCC_W'(fill);
      exp.accepted_count = tally;
      awaited.insert(awaited.size(), exp);
    endfunction

    // Called for every accepted output transaction.
    task check_result(window_stats_t got);
      window_stats_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: median %0h occupancy %0d",
                         got.median, got.occupancy));
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      results_checked++;
      if (got.median !== exp.median)
        report($sformatf("result %0d median %0h, expected %0h",
                         results_checked, got.median, exp.median));
      if (got.mean !== exp.mean)
        report($sformatf("result %0d mean %0h, expected %0h",
                         results_checked, got.mean, exp.mean));
      if (got.minimum !== exp.minimum)
        report($sformatf("result %0d minimum %0h, expected %0h",
                         results_checked, got.minimum, exp.minimum));
      if (got.maximum !== exp.maximum)
        report($sformatf("result %0d maximum %0h, expected %0h",
                         results_checked, got.maximum, exp.maximum));
      if (got.occupancy !== exp.occupancy)
        report($sformatf("result %0d occupancy %0d, expected %0d",
                         results_checked, got.occupancy, exp.occupancy));
      if (got.accepted_count !== exp.accepted_count)
        report($sformatf("result %0d accepted_count %0d, expected %0d",
                         results_checked, got.accepted_count, exp.accepted_count));
      if (got.taken !== exp.taken)
        report($sformatf("result %0d taken %0b, expected %0b",
                         results_checked, got.taken, exp.taken));
    endtask

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  // All block inputs start at known values before the first edge.
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                command   = CMD_OFFER;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_ready = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [VAL_W-1:0]    median;
  logic [VAL_W-1:0]    mean;
  logic [VAL_W-1:0]    minimum;
  logic [VAL_W-1:0]    maximum;
  logic [OCC_W-1:0]    occupancy;
  logic [CNT_W-1:0]    accepted_count;
  logic                taken;

  window_scoreboard sb = new();

  // When the sender is calm it offers back-to-back transactions.
  bit sender_calm = 1'b0;

  sliding_window_median_stats #(.WINDOW(DEPTH)) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .median         (median),
    .mean           (mean),
    .minimum        (minimum),
    .maximum        (maximum),
    .occupancy      (occupancy),
    .accepted_count (accepted_count),
    .taken          (taken)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses a transaction.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("TIMEOUT with %0d results still awaited", sb.outstanding());
    $display("end of test: mismatches");
    $finish;
  end

  // Gaps between input transactions: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Presents one transaction at a falling edge and holds it until the block
  // accepts it at a rising edge. When there is no gap, valid simply stays
  // high and only the payload changes.
  task automatic drive_item(input logic cmd, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    command  <= cmd;
    sample   <= smp;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, smp);
  endtask

  // A non-positive sample: zero, the most negative value, or anything between.
  function automatic logic [SAMPLE_W-1:0] non_positive();
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) == 0) return '0;
    v[SAMPLE_W-1] = 1'b1;
    return v;
  endfunction

  // A positive sample shaped by the current flavor. Small values give many
  // duplicates, which matter when an evicted value appears more than once;
  // values near the top stress the window sum and the median pair sum.
  function automatic logic [SAMPLE_W-1:0] positive(int flavor);
    logic [SAMPLE_W-1:0] v;
    case (flavor)
      0: begin
        v = $urandom_range(1, 8);
      end
      1: begin
        v = 32'h7FFF_FFFF - $urandom_range(0, 255);
      end
      2: begin
        v = $urandom_range(1, 32'h0004_0000);
      end
      default: begin
        v = $urandom;
        v[SAMPLE_W-1] = 1'b0;
        if (v == '0) v = 32'd1;
      end
    endcase
    return v;
  endfunction

  // Output side: the receiver stalls at random, with long stretches of
  // steady readiness mixed in, so stalls land on every stage of the work.
  int  stall_left     = 0;
  int  out_phase_left = 0;
  bit  receiver_calm  = 1'b0;

  always @(negedge clk) begin
    if (out_phase_left == 0) begin
      receiver_calm  <= ($urandom_range(0, 3) == 0);
      out_phase_left <= $urandom_range(50, 400);
    end else begin
      out_phase_left <= out_phase_left - 1;
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!receiver_calm && $urandom_range(0, 99) < 30) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                 : $urandom_range(10, 80);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted output transaction is checked against the oldest
  // prediction. Outputs are read at the rising edge, before the block's
  // own registers update.
  always @(posedge clk) begin
    window_stats_t got;
    if (!rst && out_valid && out_ready) begin
      got.median         = median;
      got.mean           = mean;
      got.minimum        = minimum;
      got.maximum        = maximum;
      got.occupancy      = occupancy;
      got.accepted_count = accepted_count;
      got.taken          = taken;
      sb.check_result(got);
    end
  end

  initial begin
    int flavor;
    int burst_left;
    int calm_left;
    int r;

    flavor     = 0;
    burst_left = 0;
    calm_left  = 0;

    // Synchronous reset, held for a fixed number of cycles and released once.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The empty window reports zeros; non-positive samples
    // are dropped without touching the window; a clear ignores its sample.
    drive_item(CMD_OFFER, 32'h0000_0000);
    drive_item(CMD_OFFER, 32'h8000_0000);
    drive_item(CMD_OFFER, 32'hFFFF_FFFF);
    drive_item(CMD_CLEAR, 32'h0000_0000);
    drive_item(CMD_OFFER, 32'h0000_0001);
    drive_item(CMD_OFFER, 32'h7FFF_FFFF);
    drive_item(CMD_OFFER, 32'h7FFF_FFFE);
    // Even count with the two largest values in the middle: the pair sum
    // needs the extra bit.
    drive_item(CMD_OFFER, 32'h7FFF_FFFF);
    drive_item(CMD_OFFER, 32'hFFFF_FFFE);
    drive_item(CMD_OFFER, 32'h0000_0000);
    drive_item(CMD_CLEAR, 32'h7FFF_FFFF);
    drive_item(CMD_OFFER, 32'hFFFF_0000);
    drive_item(CMD_CLEAR, 32'h8000_0000);
    drive_item(CMD_CLEAR, 32'hFFFF_FFFF);
    // Duplicates and a smaller value that sorts below them.
    drive_item(CMD_OFFER, 32'h0000_0005);
    drive_item(CMD_OFFER, 32'h0000_0005);
    drive_item(CMD_OFFER, 32'h0000_0003);
    drive_item(CMD_OFFER, 32'h0000_0005);
    drive_item(CMD_OFFER, 32'h0001_0000);
    drive_item(CMD_OFFER, 32'h5555_5555);
    drive_item(CMD_OFFER, 32'h2AAA_AAAA);
    drive_item(CMD_OFFER, 32'h0000_0002);
    drive_item(CMD_CLEAR, 32'h1234_5678);

    // Random part. Clears are rare so the window fills and then evicts for
    // long stretches; drops are sprinkled in as noise. The value flavor and
    // the sender's calm mode change in bursts.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        flavor     = $urandom_range(0, 3);
        burst_left = $urandom_range(20, 150);
      end else begin
        burst_left--;
      end
      if (calm_left == 0) begin
        sender_calm = ($urandom_range(0, 3) == 0);
        calm_left   = $urandom_range(30, 200);
      end else begin
        calm_left--;
      end
      r = $urandom_range(0, 999);
      if (r < 5)
        drive_item(CMD_CLEAR, $urandom);
      else if (r < 85)
        drive_item(CMD_OFFER, non_positive());
      else
        drive_item(CMD_OFFER, positive(flavor));
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every awaited result, then give a slow extra result a chance
    // to appear before closing.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d clears, %0d dropped samples.",
             sb.items_seen, sb.clears_seen, sb.drops_seen);
    $display("Checked %0d results; %0d samples went in by evicting the oldest.",
             sb.results_checked, sb.evictions_seen);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sliding_window_median_stats.f
design/slwm_pkg.sv
design/slwm_divider.sv
design/slwm_sort_engine.sv
design/sliding_window_median_stats.sv
test/testbench.sv
